// ----- hdl/bmcb_pkg.sv -----
// Shared types and codes for the bounded min candidate buffer.
`default_nettype none
package bmcb_pkg;

  localparam int KEY_W = 32;
  localparam int ID_W = 31;
  localparam int CNT_OUT_W = 7;
  localparam int CAP_W = 7;
  localparam int REQ_W = 2;
  localparam int CMP_SEL_W = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd16;

  localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_COUNT = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

  localparam logic [CMP_SEL_W-1:0] CMP_APPEND = 2'd0;
  localparam logic [CMP_SEL_W-1:0] CMP_EVICT = 2'd1;
  localparam logic [CMP_SEL_W-1:0] CMP_BEST = 2'd2;
  localparam logic [CMP_SEL_W-1:0] CMP_THRESH = 2'd3;

  typedef struct packed {
    logic             live;
    logic [ID_W-1:0]  ident;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef struct packed {
    logic [KEY_W-1:0] new_key;
    logic [KEY_W-1:0] held_key;
    logic [KEY_W-1:0] max_key;
    logic [KEY_W-1:0] best_key;
    logic [KEY_W-1:0] rd_key;
    logic [KEY_W-1:0] thresh;
  } cmp_opnd_t;

endpackage
`default_nettype wire

// ----- hdl/bmcb_mem.sv -----
// Slot store: one write port, one registered read port.
`default_nettype none
module bmcb_mem #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW-1:0]      waddr,
  input  wire bmcb_pkg::entry_t   wdata,
  input  wire logic               re,
  input  wire logic [AW-1:0]      raddr,
  output bmcb_pkg::entry_t        rdata
);

  bmcb_pkg::entry_t mem [DEPTH];
  bmcb_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hdl/bmcb_cmp.sv -----
// Shared unsigned key comparator with operand select.
`default_nettype none
module bmcb_cmp (
  input  wire logic [bmcb_pkg::CMP_SEL_W-1:0] sel,
  input  wire bmcb_pkg::cmp_opnd_t            opnd,
  output logic                                lt
);

  logic [bmcb_pkg::KEY_W-1:0] a;
  logic [bmcb_pkg::KEY_W-1:0] b;

  always_comb begin
    unique case (sel)
      bmcb_pkg::CMP_APPEND: begin
        a = opnd.max_key;
        b = opnd.new_key;
      end
      bmcb_pkg::CMP_EVICT: begin
        a = opnd.held_key;
        b = opnd.max_key;
      end
      bmcb_pkg::CMP_BEST: begin
        a = opnd.best_key;
        b = opnd.rd_key;
      end
      bmcb_pkg::CMP_THRESH: begin
        a = opnd.rd_key;
        b = opnd.thresh;
      end
      default: begin
        a = opnd.rd_key;
        b = opnd.thresh;
      end
    endcase
  end

  assign lt = a < b;

endmodule
`default_nettype wire

// ----- hdl/bounded_min_candidate_buffer.sv -----
// Top level: request sequencer, slot store and shared comparator of the candidate buffer.
// Push into a store below capacity, clear: go from accept to the done state, then to the output register.
// Push into a full store: dropped when its key is not below the largest, else it evicts that slot (max rescan).
// Pop and count: a scan over the filled slots; one slot read and one compare per cycle.
// One request at a time; the next is accepted once the result is in the output register.
// rst_n (synchronous, active low) empties the store and sets capacity to 16; no clearing pass.
`default_nettype none
module bounded_min_candidate_buffer #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bmcb_pkg::REQ_W-1:0]        in_req_type,
  input  wire logic [bmcb_pkg::ID_W-1:0]         in_node_id,
  input  wire logic [bmcb_pkg::KEY_W-1:0]        in_key,
  input  wire logic [bmcb_pkg::KEY_W-1:0]        in_threshold,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic                                   out_ok,
  output logic [bmcb_pkg::ID_W-1:0]              out_id,
  output logic [bmcb_pkg::KEY_W-1:0]             out_key,
  output logic [bmcb_pkg::CNT_OUT_W-1:0]         out_below_count,
  output logic [bmcb_pkg::CNT_OUT_W-1:0]         out_live_count,
  output logic [bmcb_pkg::KEY_W-1:0]             out_largest_key,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [2:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVICT = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [bmcb_pkg::CAP_W-1:0] cap_r;
  logic [bmcb_pkg::REQ_W-1:0] req_r, req_nxt;
  logic [bmcb_pkg::ID_W-1:0] id_r, id_nxt;
  logic [bmcb_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [bmcb_pkg::KEY_W-1:0] thr_r, thr_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic rvalid_r, rvalid_nxt;
  logic [AW-1:0] rslot_r, rslot_nxt;
  logic [bmcb_pkg::KEY_W-1:0] best_key_r, best_key_nxt;
  logic [bmcb_pkg::ID_W-1:0] best_id_r, best_id_nxt;
  logic [AW-1:0] best_slot_r, best_slot_nxt;
  logic found_r, found_nxt;
  logic ok_r, ok_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] live_r, live_nxt;
  logic [bmcb_pkg::KEY_W-1:0] max_key_r, max_key_nxt;
  logic [AW-1:0] max_slot_r, max_slot_nxt;

  logic out_valid_r, out_valid_nxt;
  logic out_ok_r, out_ok_nxt;
  logic [bmcb_pkg::ID_W-1:0] out_id_r, out_id_nxt;
  logic [bmcb_pkg::KEY_W-1:0] out_key_r, out_key_nxt;
  logic [bmcb_pkg::CNT_OUT_W-1:0] out_below_r, out_below_nxt;
  logic [bmcb_pkg::CNT_OUT_W-1:0] out_live_r, out_live_nxt;
  logic [bmcb_pkg::KEY_W-1:0] out_largest_r, out_largest_nxt;

  logic mem_we;
  logic [AW-1:0] mem_waddr;
  bmcb_pkg::entry_t mem_wdata;
  logic mem_re;
  logic [AW-1:0] mem_raddr;
  bmcb_pkg::entry_t mem_rdata;

  logic [bmcb_pkg::CMP_SEL_W-1:0] cmp_sel;
  bmcb_pkg::cmp_opnd_t cmp_opnd;
  logic cmp_lt;

  logic [CW-1:0] eff_cap;
  logic full;
  logic accept;
  logic cfg_wr;
  logic pop_hit;

  bmcb_mem #(
    .DEPTH(MAX_ENTRIES),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  bmcb_cmp u_cmp (
    .sel(cmp_sel),
    .opnd(cmp_opnd),
    .lt(cmp_lt)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, cap_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= bmcb_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      cap_r <= pwdata[bmcb_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CW'(1);
    end else if (32'(cap_r) > 32'(MAX_ENTRIES)) begin
      eff_cap = CW'(MAX_ENTRIES);
    end else begin
      eff_cap = CW'(cap_r);
    end
  end

  assign full = fill_r >= eff_cap;
  assign in_stall = state_r != S_IDLE;
  assign accept = in_valid && !in_stall;
  assign pop_hit = (req_r == bmcb_pkg::REQ_POP) && ok_r;

  assign cmp_opnd.new_key = in_key;
  assign cmp_opnd.held_key = key_r;
  assign cmp_opnd.max_key = max_key_r;
  assign cmp_opnd.best_key = best_key_r;
  assign cmp_opnd.rd_key = mem_rdata.key;
  assign cmp_opnd.thresh = thr_r;

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    id_nxt = id_r;
    key_nxt = key_r;
    thr_nxt = thr_r;
    idx_nxt = idx_r;
    rvalid_nxt = 1'b0;
    rslot_nxt = rslot_r;
    best_key_nxt = best_key_r;
    best_id_nxt = best_id_r;
    best_slot_nxt = best_slot_r;
    found_nxt = found_r;
    ok_nxt = ok_r;
    cnt_nxt = cnt_r;
    fill_nxt = fill_r;
    live_nxt = live_r;
    max_key_nxt = max_key_r;
    max_slot_nxt = max_slot_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt = out_ok_r;
    out_id_nxt = out_id_r;
    out_key_nxt = out_key_r;
    out_below_nxt = out_below_r;
    out_live_nxt = out_live_r;
    out_largest_nxt = out_largest_r;
    mem_we = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re = 1'b0;
    mem_raddr = max_slot_r;
    cmp_sel = bmcb_pkg::CMP_APPEND;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        cmp_sel = bmcb_pkg::CMP_APPEND;
        if (accept) begin
          req_nxt = in_req_type;
          id_nxt = in_node_id;
          key_nxt = in_key;
          thr_nxt = in_threshold;
          idx_nxt = '0;
          found_nxt = 1'b0;
          cnt_nxt = '0;
          ok_nxt = 1'b0;
          mem_re = 1'b1;
          unique case (in_req_type)
            bmcb_pkg::REQ_PUSH: begin
              if (!full) begin
                mem_we = 1'b1;
                mem_waddr = fill_r[AW-1:0];
                mem_wdata = '{live: 1'b1, ident: in_node_id, key: in_key};
                fill_nxt = fill_r + CW'(1);
                live_nxt = live_r + CW'(1);
                ok_nxt = 1'b1;
                if (fill_r == '0 || cmp_lt) begin
                  max_key_nxt = in_key;
                  max_slot_nxt = fill_r[AW-1:0];
                end
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_EVICT;
              end
            end
            bmcb_pkg::REQ_POP, bmcb_pkg::REQ_COUNT: begin
              state_nxt = S_SCAN;
            end
            bmcb_pkg::REQ_CLEAR: begin
              fill_nxt = '0;
              live_nxt = '0;
              max_key_nxt = '0;
              max_slot_nxt = '0;
              state_nxt = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_EVICT: begin
        cmp_sel = bmcb_pkg::CMP_EVICT;
        if (cmp_lt) begin
          mem_we = 1'b1;
          mem_waddr = max_slot_r;
          mem_wdata = '{live: 1'b1, ident: id_r, key: key_r};
          if (!mem_rdata.live) begin
            live_nxt = live_r + CW'(1);
          end
          ok_nxt = 1'b1;
          idx_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        cmp_sel = (req_r == bmcb_pkg::REQ_COUNT) ? bmcb_pkg::CMP_THRESH : bmcb_pkg::CMP_BEST;
        if (idx_r < fill_r) begin
          mem_re = 1'b1;
          mem_raddr = idx_r[AW-1:0];
          rslot_nxt = idx_r[AW-1:0];
          idx_nxt = idx_r + CW'(1);
          rvalid_nxt = 1'b1;
        end
        if (rvalid_r) begin
          priority if (req_r == bmcb_pkg::REQ_COUNT) begin
            if (cmp_lt) begin
              cnt_nxt = cnt_r + CW'(1);
            end
          end else if (req_r == bmcb_pkg::REQ_POP) begin
            if (mem_rdata.live && (!found_r || !cmp_lt)) begin
              best_key_nxt = mem_rdata.key;
              best_id_nxt = mem_rdata.ident;
              best_slot_nxt = rslot_r;
              found_nxt = 1'b1;
            end
          end else begin
            if (!found_r || cmp_lt) begin
              best_key_nxt = mem_rdata.key;
              best_id_nxt = mem_rdata.ident;
              best_slot_nxt = rslot_r;
              found_nxt = 1'b1;
            end
          end
        end
        if (!rvalid_r && idx_r >= fill_r) begin
          if (req_r == bmcb_pkg::REQ_PUSH) begin
            max_key_nxt = best_key_r;
            max_slot_nxt = best_slot_r;
          end else if (req_r == bmcb_pkg::REQ_POP && found_r) begin
            mem_we = 1'b1;
            mem_waddr = best_slot_r;
            mem_wdata = '{live: 1'b0, ident: best_id_r, key: best_key_r};
            if (live_r != '0) begin
              live_nxt = live_r - CW'(1);
            end
            ok_nxt = 1'b1;
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt = ok_r;
          out_id_nxt = pop_hit ? best_id_r : '0;
          out_key_nxt = pop_hit ? best_key_r : '0;
          out_below_nxt = (req_r == bmcb_pkg::REQ_COUNT) ?
                          bmcb_pkg::CNT_OUT_W'(cnt_r) : '0;
          out_live_nxt = bmcb_pkg::CNT_OUT_W'(live_r);
          out_largest_nxt = (fill_r != '0) ? max_key_r : '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      rvalid_r <= 1'b0;
      fill_r <= '0;
      live_r <= '0;
      max_key_r <= '0;
      max_slot_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rvalid_r <= rvalid_nxt;
      fill_r <= fill_nxt;
      live_r <= live_nxt;
      max_key_r <= max_key_nxt;
      max_slot_r <= max_slot_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    id_r <= id_nxt;
    key_r <= key_nxt;
    thr_r <= thr_nxt;
    idx_r <= idx_nxt;
    rslot_r <= rslot_nxt;
    best_key_r <= best_key_nxt;
    best_id_r <= best_id_nxt;
    best_slot_r <= best_slot_nxt;
    found_r <= found_nxt;
    ok_r <= ok_nxt;
    cnt_r <= cnt_nxt;
    out_ok_r <= out_ok_nxt;
    out_id_r <= out_id_nxt;
    out_key_r <= out_key_nxt;
    out_below_r <= out_below_nxt;
    out_live_r <= out_live_nxt;
    out_largest_r <= out_largest_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_ok = out_ok_r;
  assign out_id = out_id_r;
  assign out_key = out_key_r;
  assign out_below_count = out_below_r;
  assign out_live_count = out_live_r;
  assign out_largest_key = out_largest_r;

`ifndef SYNTHESIS
  a_live_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= fill_r)
    else $error("live count exceeds fill count");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(MAX_ENTRIES))
    else $error("fill count beyond store depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("sequencer idle right after accepting a request");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> out_valid_r && state_r == S_IDLE)
    else $error("finished request not moved to output register");
`endif

endmodule
`default_nettype wire
